FILE: hdl/assert_macros.svh
// assertion macros shared by the valve controller modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define PFVC_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define PFVC_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/pfvc_pkg.sv
// types and constants for the pneumatic finger valve controller
// no dependencies
`default_nettype none

package pfvc_pkg;

  localparam int NUM_FINGERS  = 5;
  localparam int CMD_LEN      = 16;
  localparam int DIGIT_W      = 4;
  localparam int CNT_W        = $clog2(CMD_LEN);
  localparam int CHAR_W       = 6;
  localparam int SIDX_W       = 3;
  localparam int ROLL_W       = 10;
  localparam int ANGLE_W      = 9;
  localparam int TGT_W        = 11;
  localparam int CODE_W       = 8;
  localparam int PUMP_W       = 16;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int POSE_FINGERS = (NUM_FINGERS < 5) ? NUM_FINGERS : 5;
  localparam int WRAP_DEG     = 360;

  localparam logic [DIGIT_W-1:0] POSE_MODE_DIGIT = DIGIT_W'(1);
  localparam logic [DIGIT_W-1:0] INFLATE_BANK    = DIGIT_W'(0);
  localparam logic [CODE_W-1:0]  BTN_FIRST       = CODE_W'(1);
  localparam logic [CODE_W-1:0]  BTN_LAST_SINGLE = CODE_W'(10);
  localparam logic [CODE_W-1:0]  BTN_ALL_OPEN    = CODE_W'(11);
  localparam logic [CODE_W-1:0]  BTN_ALL_CLOSE   = CODE_W'(12);

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_ANGLE = 2'd1,
    CMD_PANEL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef logic [NUM_FINGERS-1:0] fmask_t;

  // decoded item: set/clear masks for both valve banks plus panel levels
  typedef struct packed {
    fmask_t infl_set;
    fmask_t infl_clr;
    fmask_t exh_set;
    fmask_t exh_clr;
    logic   lvl_wr;
    logic   manual;
    logic   pump_off;
    logic   applied;
  } op_t;

endpackage

`default_nettype wire

FILE: hdl/pfvc_if.sv
// valid/ready channel interfaces for items, results and configuration
// depends on pfvc_pkg
`default_nettype none

interface pfvc_in_if;
  import pfvc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [CHAR_W-1:0]   char_code;
  logic [SIDX_W-1:0]   sensor_index;
  logic signed [ROLL_W-1:0] roll_degrees;
  logic                sw_all_mode;
  logic                sw_all_in;
  logic                sw_all_out;
  logic                sw_manual;
  logic                sw_pump_off;

  modport source (output valid, cmd, char_code, sensor_index, roll_degrees,
                  sw_all_mode, sw_all_in, sw_all_out, sw_manual, sw_pump_off,
                  input ready);
  modport sink (input valid, cmd, char_code, sensor_index, roll_degrees,
                sw_all_mode, sw_all_in, sw_all_out, sw_manual, sw_pump_off,
                output ready);
endinterface

interface pfvc_out_if;
  import pfvc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [NUM_FINGERS-1:0] inflate_closed;
  logic [NUM_FINGERS-1:0] exhaust_closed;
  logic [PUMP_W-1:0]      pump_compare;
  logic                   command_applied;

  modport source (output valid, inflate_closed, exhaust_closed, pump_compare,
                  command_applied, input ready);
  modport sink (input valid, inflate_closed, exhaust_closed, pump_compare,
                command_applied, output ready);
endinterface

interface pfvc_cfg_if;
  import pfvc_pkg::*;
  logic              valid;
  logic              ready;
  logic [PUMP_W-1:0] pump_compare_value;

  modport source (output valid, pump_compare_value, input ready);
  modport sink (input valid, pump_compare_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/pfvc_front.sv
// front end: collects command digits and finger angles, decodes each item
// into valve set/clear masks; depends on pfvc_pkg, pfvc_if, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pfvc_front
  import pfvc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  pfvc_in_if.sink     in_ch,
  input  wire logic   q_full,
  output logic        op_push,
  output op_t         op
);

  logic [DIGIT_W-1:0] digit_r [CMD_LEN];
  logic [CNT_W-1:0]   char_count_r, char_count_nxt;
  logic [ANGLE_W-1:0] angle_r [NUM_FINGERS];
  logic [ANGLE_W-1:0] angle_new;
  logic [DIGIT_W-1:0] dig [CMD_LEN];
  logic [DIGIT_W-1:0] digit_in;
  logic               done;
  logic [TGT_W-1:0]   tgt [POSE_FINGERS];
  logic [CODE_W-1:0]  code;
  logic [CODE_W-1:0]  code_m1;
  fmask_t             fbit, bset, bclr;
  logic signed [ROLL_W:0] wrapped;
  cmd_t               cmd;

  assign in_ch.ready = !q_full;
  assign op_push     = in_ch.valid && !q_full;
  assign cmd         = cmd_t'(in_ch.cmd);
  assign digit_in    = in_ch.char_code[DIGIT_W-1:0];
  assign done        = (char_count_r == CNT_W'(CMD_LEN - 1));

  always_comb begin
    for (int i = 0; i < CMD_LEN; i++) begin
      dig[i] = (i == CMD_LEN - 1) ? digit_in : digit_r[i];
    end
    for (int f = 0; f < POSE_FINGERS; f++) begin
      tgt[f] = TGT_W'(dig[3*f]) * TGT_W'(100) + TGT_W'(dig[3*f+1]) * TGT_W'(10)
             + TGT_W'(dig[3*f+2]);
    end
  end

  assign code    = CODE_W'(dig[13]) * CODE_W'(10) + CODE_W'(dig[14]);
  assign code_m1 = code - BTN_FIRST;

  always_comb begin
    bset = '0;
    bclr = '0;
    for (int f = 0; f < NUM_FINGERS; f++) begin
      fbit[f] = (code_m1[CODE_W-1:1] == (CODE_W-1)'(f));
    end
    if (code >= BTN_FIRST && code <= BTN_LAST_SINGLE) begin
      if (code[0]) begin
        bclr = fbit;
      end else begin
        bset = fbit;
      end
    end else if (code == BTN_ALL_OPEN) begin
      bclr = '1;
    end else if (code == BTN_ALL_CLOSE) begin
      bset = '1;
    end
  end

  assign wrapped   = $signed({in_ch.roll_degrees[ROLL_W-1], in_ch.roll_degrees})
                   + $signed((ROLL_W+1)'(WRAP_DEG));
  assign angle_new = in_ch.roll_degrees[ROLL_W-1]
                   ? (wrapped[ROLL_W] ? '0 : wrapped[ANGLE_W-1:0])
                   : in_ch.roll_degrees[ANGLE_W-1:0];

  always_comb begin
    op             = '0;
    char_count_nxt = char_count_r;
    case (cmd)
      CMD_CHAR: begin
        char_count_nxt = done ? '0 : char_count_r + CNT_W'(1);
        if (done) begin
          op.applied = 1'b1;
          if (digit_in == POSE_MODE_DIGIT) begin
            for (int f = 0; f < POSE_FINGERS; f++) begin
              op.infl_clr[f] = (TGT_W'(angle_r[f]) < tgt[f]);
              op.infl_set[f] = !(TGT_W'(angle_r[f]) < tgt[f]);
              op.exh_set[f]  = 1'b1;
            end
          end else if (dig[0] == INFLATE_BANK) begin
            op.infl_set = bset;
            op.infl_clr = bclr;
          end else begin
            op.exh_set = bset;
            op.exh_clr = bclr;
          end
        end
      end
      CMD_PANEL: begin
        op.lvl_wr   = 1'b1;
        op.manual   = in_ch.sw_manual;
        op.pump_off = in_ch.sw_pump_off;
        if (in_ch.sw_all_mode) begin
          op.infl_clr = in_ch.sw_all_in ? '0 : '1;
          op.exh_clr  = in_ch.sw_all_out ? '0 : '1;
        end
      end
      CMD_ANGLE, CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r <= '0;
      for (int f = 0; f < NUM_FINGERS; f++) begin
        angle_r[f] <= '0;
      end
    end else if (op_push) begin
      char_count_r <= char_count_nxt;
      if (cmd == CMD_ANGLE) begin
        for (int f = 0; f < NUM_FINGERS; f++) begin
          if (in_ch.sensor_index == SIDX_W'(f)) begin
            angle_r[f] <= angle_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_push && cmd == CMD_CHAR) begin
      digit_r[char_count_r] <= digit_in;
    end
  end

  `PFVC_ASSERT_NXT(a_applied_wraps, clk, rst_n, op_push && op.applied, char_count_r == '0,
    "completed command did not restart digit count")

endmodule

`default_nettype wire

FILE: hdl/pfvc_queue.sv
// short queue of decoded items between front and back
// depends on pfvc_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pfvc_queue
  import pfvc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  output logic      q_valid,
  output op_t       q_op,
  input  wire logic q_ready
);

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_op    = mem_r[rd_ptr_r];
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  `PFVC_ASSERT_NXT(a_drain_empty, clk, rst_n, cnt_r == QCNT_W'(1) && pop && !push, !q_valid,
    "queue not empty after last item left")

endmodule

`default_nettype wire

FILE: hdl/pfvc_back.sv
// back end: applies decoded items to valve pins and pump levels, holds the
// pump compare register and the result register; depends on pfvc_pkg, pfvc_if, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pfvc_back
  import pfvc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire op_t  q_op,
  output logic      q_ready,
  pfvc_cfg_if.sink  cfg_ch,
  pfvc_out_if.source out_ch
);

  fmask_t            infl_r, infl_nxt;
  fmask_t            exh_r, exh_nxt;
  logic              manual_r, manual_nxt;
  logic              pump_off_r, pump_off_nxt;
  logic [PUMP_W-1:0] pump_cfg_r;
  logic              run;
  logic              pop;
  logic              out_valid_r;
  fmask_t            out_infl_r, out_exh_r;
  logic [PUMP_W-1:0] out_pump_r;
  logic              out_applied_r;

  assign cfg_ch.ready = 1'b1;
  assign q_ready      = !out_valid_r || out_ch.ready;
  assign pop          = q_valid && q_ready;

  assign infl_nxt     = (infl_r & ~q_op.infl_clr) | q_op.infl_set;
  assign exh_nxt      = (exh_r & ~q_op.exh_clr) | q_op.exh_set;
  assign manual_nxt   = q_op.lvl_wr ? q_op.manual : manual_r;
  assign pump_off_nxt = q_op.lvl_wr ? q_op.pump_off : pump_off_r;
  assign run          = manual_nxt ? !pump_off_nxt : (infl_nxt != '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r      <= '1;
      exh_r       <= '1;
      manual_r    <= 1'b1;
      pump_off_r  <= 1'b1;
      pump_cfg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        pump_cfg_r <= cfg_ch.pump_compare_value;
      end
      if (pop) begin
        infl_r      <= infl_nxt;
        exh_r       <= exh_nxt;
        manual_r    <= manual_nxt;
        pump_off_r  <= pump_off_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_infl_r    <= infl_nxt;
      out_exh_r     <= exh_nxt;
      out_pump_r    <= run ? pump_cfg_r : '0;
      out_applied_r <= q_op.applied;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.inflate_closed  = out_infl_r;
  assign out_ch.exhaust_closed  = out_exh_r;
  assign out_ch.pump_compare    = out_pump_r;
  assign out_ch.command_applied = out_applied_r;

  `PFVC_ASSERT_NXT(a_idle_op_keeps_pins, clk, rst_n,
    pop && q_op.infl_set == '0 && q_op.infl_clr == '0,
    infl_r == $past(infl_r), "inflate pins changed on an item with no inflate action")

  `PFVC_ASSERT_IMP(a_result_matches_pins, clk, rst_n, out_valid_r && !pop,
    out_infl_r == infl_r && out_exh_r == exh_r, "held result differs from valve state")

endmodule

`default_nettype wire

FILE: hdl/pneumatic_finger_valve_controller.sv
// channel   | dir | payload
// in_ch     | in  | cmd, char_code, sensor_index, roll_degrees, sw_* panel levels
// out_ch    | out | inflate_closed, exhaust_closed, pump_compare, command_applied
// cfg_ch    | in  | pump_compare_value
//
// one item per cycle unless out_ch stalls; each item passes the queue, then the result register
// the front decodes in the accept cycle; a 4-entry queue feeds the back end
// synchronous active-low reset: all valves closed, pump off, angles and count zero
// a stalled output fills the queue, then in_ch.ready drops
// cfg_ch is always ready; depends on pfvc_pkg, pfvc_if and the three submodules
`default_nettype none

module pneumatic_finger_valve_controller
  import pfvc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfvc_in_if.sink    in_ch,
  pfvc_out_if.source out_ch,
  pfvc_cfg_if.sink   cfg_ch
);

  logic op_push;
  op_t  push_op;
  logic q_full;
  logic q_valid;
  op_t  q_op;
  logic q_ready;

  pfvc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .op_push (op_push),
    .op      (push_op)
  );

  pfvc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (push_op),
    .full    (q_full),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_ready (q_ready)
  );

  pfvc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_ready (q_ready),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: dv/pneumatic_finger_valve_controller_tb.sv
// testbench for pneumatic_finger_valve_controller: command strings, angle and panel samples
// predicts every result in step with the accepted items and compares it field by field
// depends on pfvc_pkg, pfvc_if and the controller rtl
`timescale 1ns / 100ps

module pneumatic_finger_valve_controller_tb;
  import pfvc_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_REPORTS    = 10;
  localparam int BANK_POS       = 0;
  localparam int CODE_TENS_POS  = 13;
  localparam int CODE_ONES_POS  = 14;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] EXHAUST_BANK = INFLATE_BANK + 1'b1;

  typedef logic [DIGIT_W*CMD_LEN-1:0] cmd_digits_t;

  typedef struct {
    cmd_t                     cmd;
    logic [CHAR_W-1:0]        char_code;
    logic [SIDX_W-1:0]        sensor_index;
    logic signed [ROLL_W-1:0] roll_degrees;
    logic                     sw_all_mode;
    logic                     sw_all_in;
    logic                     sw_all_out;
    logic                     sw_manual;
    logic                     sw_pump_off;
  } valve_item_t;

  typedef struct {
    fmask_t            inflate_closed;
    fmask_t            exhaust_closed;
    logic [PUMP_W-1:0] pump_compare;
    logic              command_applied;
  } valve_state_t;

  logic clk = 1'b0;
  logic rst_n;

  pfvc_in_if  in_ch ();
  pfvc_out_if out_ch ();
  pfvc_cfg_if cfg_ch ();

  pneumatic_finger_valve_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // predicted block state
  logic [DIGIT_W-1:0] digits_rx [CMD_LEN];
  logic [CNT_W-1:0]   digit_pos;
  logic [ANGLE_W-1:0] finger_deg [NUM_FINGERS];
  fmask_t             inflate_now;
  fmask_t             exhaust_now;
  logic               manual_pump;
  logic               pump_stop;
  logic [PUMP_W-1:0]  pump_setting;

  valve_state_t expected_valves_q [$];

  bit idle_enable = 1'b0;
  int sink_stall = 0;
  int stuck_cycles = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int pose_applied = 0;
  int button_applied = 0;
  int angle_samples = 0;
  int panel_samples = 0;
  int cfg_writes = 0;

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] %s", $realtime, msg);
  endfunction

  function automatic valve_state_t predict_valves(input valve_item_t it);
    valve_state_t r;
    fmask_t bank;
    int tgt;
    int code;
    int f;
    int roll;
    logic done;
    done = 1'b0;
    case (it.cmd)
      CMD_CHAR: begin
        digits_rx[digit_pos] = it.char_code[DIGIT_W-1:0];
        digit_pos = digit_pos + 1'b1;
        if (digit_pos == '0) begin
          done = 1'b1;
          if (digits_rx[CMD_LEN-1] == POSE_MODE_DIGIT) begin
            pose_applied++;
            for (f = 0; f < POSE_FINGERS; f++) begin
              tgt = 100 * int'(digits_rx[3*f]) + 10 * int'(digits_rx[3*f+1])
                  + int'(digits_rx[3*f+2]);
              inflate_now[f] = (int'(finger_deg[f]) < tgt) ? 1'b0 : 1'b1;
              exhaust_now[f] = 1'b1;
            end
          end else begin
            button_applied++;
            code = 10 * int'(digits_rx[CODE_TENS_POS]) + int'(digits_rx[CODE_ONES_POS]);
            bank = (digits_rx[BANK_POS] == INFLATE_BANK) ? inflate_now : exhaust_now;
            if (code >= BTN_FIRST && code <= BTN_LAST_SINGLE) begin
              f = (code - 1) / 2;
              if (f < NUM_FINGERS)
                bank[f] = code[0] ? 1'b0 : 1'b1;
            end else if (code == BTN_ALL_OPEN) begin
              bank = '0;
            end else if (code == BTN_ALL_CLOSE) begin
              bank = '1;
            end
            if (digits_rx[BANK_POS] == INFLATE_BANK)
              inflate_now = bank;
            else
              exhaust_now = bank;
          end
        end
      end
      CMD_ANGLE: begin
        angle_samples++;
        if (it.sensor_index < NUM_FINGERS) begin
          roll = it.roll_degrees;
          if (roll < 0)
            roll = roll + WRAP_DEG;
          if (roll < 0)
            roll = 0;
          finger_deg[it.sensor_index] = ANGLE_W'(roll);
        end
      end
      CMD_PANEL: begin
        panel_samples++;
        manual_pump = it.sw_manual;
        pump_stop = it.sw_pump_off;
        if (it.sw_all_mode) begin
          if (!it.sw_all_in)
            inflate_now = '0;
          if (!it.sw_all_out)
            exhaust_now = '0;
        end
      end
      default: begin
      end
    endcase
    r.inflate_closed = inflate_now;
    r.exhaust_closed = exhaust_now;
    if (manual_pump ? !pump_stop : (inflate_now != '1))
      r.pump_compare = pump_setting;
    else
      r.pump_compare = '0;
    r.command_applied = done;
    return r;
  endfunction

  function automatic valve_item_t random_item();
    valve_item_t it;
    it.cmd = cmd_t'($urandom_range(0, 3));
    it.char_code = CHAR_W'($urandom);
    it.sensor_index = SIDX_W'($urandom);
    it.roll_degrees = ROLL_W'($urandom);
    it.sw_all_mode = 1'($urandom);
    it.sw_all_in = 1'($urandom);
    it.sw_all_out = 1'($urandom);
    it.sw_manual = 1'($urandom);
    it.sw_pump_off = 1'($urandom);
    return it;
  endfunction

  function automatic valve_item_t char_item(input logic [DIGIT_W-1:0] value);
    valve_item_t it;
    it = random_item();
    it.cmd = CMD_CHAR;
    if (value > 4'd9 || $urandom_range(0, 29) == 0)
      it.char_code = {2'($urandom_range(0, 3)), value};
    else
      it.char_code = ASCII_ZERO + value;
    return it;
  endfunction

  function automatic valve_item_t angle_item(input int idx, input int roll);
    valve_item_t it;
    it = random_item();
    it.cmd = CMD_ANGLE;
    it.sensor_index = SIDX_W'(idx);
    it.roll_degrees = ROLL_W'(roll);
    return it;
  endfunction

  function automatic valve_item_t panel_item(input logic mode, input logic all_in,
                                             input logic all_out, input logic manual,
                                             input logic pump_off);
    valve_item_t it;
    it = random_item();
    it.cmd = CMD_PANEL;
    it.sw_all_mode = mode;
    it.sw_all_in = all_in;
    it.sw_all_out = all_out;
    it.sw_manual = manual;
    it.sw_pump_off = pump_off;
    return it;
  endfunction

  function automatic cmd_digits_t pose_digits(input int tgt [POSE_FINGERS]);
    cmd_digits_t v;
    v = '0;
    for (int f = 0; f < POSE_FINGERS; f++) begin
      v[DIGIT_W*(3*f) +: DIGIT_W]   = DIGIT_W'(tgt[f] / 100);
      v[DIGIT_W*(3*f+1) +: DIGIT_W] = DIGIT_W'((tgt[f] / 10) % 10);
      v[DIGIT_W*(3*f+2) +: DIGIT_W] = DIGIT_W'(tgt[f] % 10);
    end
    v[DIGIT_W*(CMD_LEN-1) +: DIGIT_W] = POSE_MODE_DIGIT;
    return v;
  endfunction

  function automatic cmd_digits_t button_digits(input logic [DIGIT_W-1:0] bank,
                                                input int code);
    cmd_digits_t v;
    for (int i = 0; i < CMD_LEN; i++)
      v[DIGIT_W*i +: DIGIT_W] = DIGIT_W'($urandom_range(0, 9));
    v[DIGIT_W*BANK_POS +: DIGIT_W] = bank;
    v[DIGIT_W*CODE_TENS_POS +: DIGIT_W] = DIGIT_W'(code / 10);
    v[DIGIT_W*CODE_ONES_POS +: DIGIT_W] = DIGIT_W'(code % 10);
    if ($urandom_range(0, 9) == 0)
      v[DIGIT_W*(CMD_LEN-1) +: DIGIT_W] = DIGIT_W'($urandom_range(0, 15));
    while (v[DIGIT_W*(CMD_LEN-1) +: DIGIT_W] == POSE_MODE_DIGIT)
      v[DIGIT_W*(CMD_LEN-1) +: DIGIT_W] = DIGIT_W'($urandom_range(0, 15));
    return v;
  endfunction

  task automatic send_item(input valve_item_t it);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= it.cmd;
    in_ch.char_code    <= it.char_code;
    in_ch.sensor_index <= it.sensor_index;
    in_ch.roll_degrees <= it.roll_degrees;
    in_ch.sw_all_mode  <= it.sw_all_mode;
    in_ch.sw_all_in    <= it.sw_all_in;
    in_ch.sw_all_out   <= it.sw_all_out;
    in_ch.sw_manual    <= it.sw_manual;
    in_ch.sw_pump_off  <= it.sw_pump_off;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_valves_q.push_back(predict_valves(it));
    items_sent++;
  endtask

  // pads out any partial command first so the digits land where intended
  task automatic send_command(input cmd_digits_t digits);
    while (digit_pos != '0)
      send_item(char_item(DIGIT_W'($urandom_range(0, 9))));
    for (int i = 0; i < CMD_LEN; i++)
      send_item(char_item(digits[DIGIT_W*i +: DIGIT_W]));
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_valves_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pump_compare(input logic [PUMP_W-1:0] value);
    hold_until_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.pump_compare_value <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    pump_setting = value;
    cfg_writes++;
  endtask

  task automatic test_idle_outputs();
    valve_item_t it;
    it = random_item();
    it.cmd = CMD_NONE;
    send_item(it);
    send_item(panel_item(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_angle_wrap();
    send_item(angle_item(0, -360));
    send_item(angle_item(1, -512));
    send_item(angle_item(1, -1));
    send_item(angle_item(2, -359));
    send_item(angle_item(3, 359));
    send_item(angle_item(4, 511));
    send_item(angle_item(5, 100));
    send_item(angle_item(7, -512));
  endtask

  task automatic test_pose_targets();
    send_command(pose_digits('{0, 360, 2, 999, 511}));
    send_command(pose_digits('{1, 359, 1, 0, 512}));
  endtask

  task automatic test_button_codes();
    send_command(button_digits(EXHAUST_BANK, BTN_ALL_OPEN));
    send_command(button_digits(INFLATE_BANK, BTN_FIRST + 2));
  endtask

  task automatic test_panel_overrides();
    send_item(panel_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(panel_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(panel_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_random_traffic(input int n_items, input bit with_idle);
    int start;
    int pick;
    int near;
    int tgt [POSE_FINGERS];
    cmd_digits_t v;
    start = items_sent;
    idle_enable = with_idle;
    while (items_sent - start < n_items) begin
      if (with_idle && $urandom_range(0, 19) == 0)
        idle_enable = ($urandom_range(0, 2) != 0);
      if (with_idle && $urandom_range(0, 99) == 0)
        hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        foreach (tgt[f]) begin
          near = int'(finger_deg[f]) + int'($urandom_range(0, 4)) - 2;
          tgt[f] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 999))
                 : (near < 0 ? 0 : near);
        end
        v = pose_digits(tgt);
        if ($urandom_range(0, 9) == 0)
          v[DIGIT_W*$urandom_range(0, CMD_LEN-2) +: DIGIT_W] = DIGIT_W'($urandom);
        send_command(v);
      end else if (pick < 60) begin
        send_command(button_digits(
          ($urandom_range(0, 1) == 0) ? INFLATE_BANK : DIGIT_W'($urandom_range(1, 15)),
          ($urandom_range(0, 9) == 0) ? int'($urandom_range(16, 99))
                                      : int'($urandom_range(0, 15))));
      end else if (pick < 78) begin
        send_item(angle_item($urandom_range(0, 7),
          ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 1023)) - 512
                                      : int'($urandom_range(0, 718)) - 359));
      end else if (pick < 88) begin
        send_item(panel_item(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                             1'($urandom)));
      end else if (pick < 94) begin
        repeat ($urandom_range(1, CMD_LEN - 1))
          send_item(char_item(DIGIT_W'($urandom)));
      end else begin
        send_item(random_item());
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    valve_state_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (expected_valves_q.size() == 0) begin
        note_error($sformatf("result with nothing expected: infl %b exh %b pump %h app %b",
                             out_ch.inflate_closed, out_ch.exhaust_closed,
                             out_ch.pump_compare, out_ch.command_applied));
      end else begin
        want = expected_valves_q.pop_front();
        if (out_ch.inflate_closed !== want.inflate_closed ||
            out_ch.exhaust_closed !== want.exhaust_closed ||
            out_ch.pump_compare !== want.pump_compare ||
            out_ch.command_applied !== want.command_applied)
          note_error($sformatf({"mismatch: expected infl %b exh %b pump %h app %b,",
                                " got infl %b exh %b pump %h app %b"},
                               want.inflate_closed, want.exhaust_closed,
                               want.pump_compare, want.command_applied,
                               out_ch.inflate_closed, out_ch.exhaust_closed,
                               out_ch.pump_compare, out_ch.command_applied));
      end
    end
  end

  always @(posedge clk) begin
    if (sink_stall > 0) begin
      sink_stall--;
      out_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 6) == 0) begin
      sink_stall = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n                     <= 1'b0;
    in_ch.valid               <= 1'b0;
    in_ch.cmd                 <= '0;
    in_ch.char_code           <= '0;
    in_ch.sensor_index        <= '0;
    in_ch.roll_degrees        <= '0;
    in_ch.sw_all_mode         <= 1'b0;
    in_ch.sw_all_in           <= 1'b0;
    in_ch.sw_all_out          <= 1'b0;
    in_ch.sw_manual           <= 1'b0;
    in_ch.sw_pump_off         <= 1'b0;
    cfg_ch.valid              <= 1'b0;
    cfg_ch.pump_compare_value <= '0;
    foreach (digits_rx[i])
      digits_rx[i] = '0;
    foreach (finger_deg[f])
      finger_deg[f] = '0;
    digit_pos    = '0;
    inflate_now  = '1;
    exhaust_now  = '1;
    manual_pump  = 1'b1;
    pump_stop    = 1'b1;
    pump_setting = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_pump_compare('1);
    idle_enable = 1'b1;
    test_idle_outputs();
    test_angle_wrap();
    test_pose_targets();
    test_button_codes();
    test_panel_overrides();

    write_pump_compare('0);
    test_random_traffic(350, 1'b1);
    write_pump_compare(PUMP_W'($urandom));
    test_random_traffic(400, 1'b1);
    write_pump_compare(PUMP_W'(1));
    test_random_traffic(400, 1'b1);
    write_pump_compare(PUMP_W'($urandom));
    test_random_traffic(350, 1'b0);

    hold_until_drained();
    if (expected_valves_q.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_valves_q.size()));

    $display("run covered %0d items and %0d results: %0d pose and %0d button commands,",
             items_sent, results_seen, pose_applied, button_applied);
    $display("%0d angle samples, %0d panel samples, %0d pump compare settings, %0d errors",
             angle_samples, panel_samples, cfg_writes, error_count);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
